### src/pfb_pkg.sv
// shared types and constants for the page-organized frame store engine
// request and result payload structs, request codes, controller/datapath links
// no dependencies
package pfb_pkg;

  localparam int DEF_WIDTH  = 128;
  localparam int DEF_HEIGHT = 64;
  localparam int DEF_PAGES  = 8;

  localparam logic [2:0] REQ_WRITE  = 3'd0;
  localparam logic [2:0] REQ_READ   = 3'd1;
  localparam logic [2:0] REQ_INVERT = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_FLUSH  = 3'd4;

  localparam logic [7:0] CMD_PAGE  = 8'hB0;
  localparam logic [7:0] CMD_START = 8'h40;
  localparam logic [7:0] CMD_COLH  = 8'h10;
  localparam logic [7:0] NIBBLE    = 8'h0F;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] x_coord;
    logic [6:0] y_coord;
    logic       write_value;
    logic [2:0] page_index;
  } in_req_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  byte_count;
    logic        is_command;
    logic        read_pixel;
    logic        last;
  } out_res_t;

  typedef struct packed {
    logic capture;
    logic emit_cmd;
    logic pix_done;
    logic clr_step;
    logic fl_rd;
  } pfb_cmd_t;

  typedef struct packed {
    logic clr_end;
    logic col_end;
  } pfb_sts_t;

endpackage

### src/pfb_ctrl.sv
// controller state machine for the frame store engine
// sequences pixel, clear and flush requests; uses pfb_pkg
module pfb_ctrl #(
  parameter int PAGES = pfb_pkg::DEF_PAGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        req_type,
  input  logic [2:0]        page_index,
  input  pfb_pkg::pfb_sts_t sts,
  output pfb_pkg::pfb_cmd_t cmd,
  output logic              busy
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PIX    = 5'b00010,
    ST_CLEAR  = 5'b00100,
    ST_FRD    = 5'b01000,
    ST_FDRAIN = 5'b10000
  } pfb_state_t;

  pfb_state_t state_r, state_nxt;
  logic       page_ok;

  assign page_ok = 32'(page_index) < PAGES;
  assign busy    = state_r != ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (req_type)
            pfb_pkg::REQ_WRITE, pfb_pkg::REQ_READ, pfb_pkg::REQ_INVERT: begin
              state_nxt = ST_PIX;
            end
            pfb_pkg::REQ_CLEAR: begin
              state_nxt = ST_CLEAR;
            end
            pfb_pkg::REQ_FLUSH: begin
              if (page_ok) begin
                cmd.emit_cmd = 1'b1;
                state_nxt    = ST_FRD;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_PIX: begin
        cmd.pix_done = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_end) state_nxt = ST_IDLE;
      end
      ST_FRD: begin
        cmd.fl_rd = 1'b1;
        if (sts.col_end) state_nxt = ST_FDRAIN;
      end
      ST_FDRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // reset starts with a clearing pass over the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/pfb_datapath.sv
// datapath for the frame store engine: byte store, pixel modify, page packing
// driven by pfb_ctrl commands; uses pfb_pkg
module pfb_datapath #(
  parameter int WIDTH  = pfb_pkg::DEF_WIDTH,
  parameter int HEIGHT = pfb_pkg::DEF_HEIGHT,
  parameter int PAGES  = pfb_pkg::DEF_PAGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pfb_pkg::in_req_t  in_req,
  input  pfb_pkg::pfb_cmd_t cmd,
  output pfb_pkg::pfb_sts_t sts,
  output logic              out_strobe,
  output pfb_pkg::out_res_t out_res
);

  localparam int DEPTH = PAGES * WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(WIDTH);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_ra, mem_wa;
  logic [7:0]    mem_wd;

  logic [AW-1:0] pix_addr, fl_addr;
  logic          pix_inside;

  logic [AW-1:0] addr_r;
  logic [2:0]    bit_r;
  logic          inside_r;
  logic [2:0]    type_r;
  logic          val_r;
  logic [2:0]    page_r;

  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          pack_d_r;
  logic [CW-1:0] col_d_r;
  logic [63:0]   word_r;

  logic [7:0]    pix_mask, mod_byte;
  logic [2:0]    slot;
  logic [63:0]   word_ins;
  logic          group_end, page_end;

  logic          out_valid_r, out_valid_nxt;
  pfb_pkg::out_res_t out_res_r, out_res_nxt;

  assign pix_addr   = AW'(32'(in_req.y_coord[6:3]) * WIDTH + 32'(in_req.x_coord));
  assign pix_inside = (32'(in_req.x_coord) < WIDTH) && (32'(in_req.y_coord) < HEIGHT)
                      && (32'(in_req.y_coord[6:3]) < PAGES);
  assign fl_addr    = AW'(32'(page_r) * WIDTH + 32'(col_r));

  assign sts.clr_end = sweep_r == AW'(DEPTH - 1);
  assign sts.col_end = col_r == CW'(WIDTH - 1);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r   <= pix_addr;
      bit_r    <= in_req.y_coord[2:0];
      inside_r <= pix_inside;
      type_r   <= in_req.req_type;
      val_r    <= in_req.write_value;
      page_r   <= in_req.page_index;
    end
  end

  // pixel read-modify-write
  assign pix_mask = 8'd1 << bit_r;
  always_comb begin
    if (type_r == pfb_pkg::REQ_INVERT) begin
      mod_byte = mem_q ^ pix_mask;
    end else if (val_r) begin
      mod_byte = mem_q | pix_mask;
    end else begin
      mod_byte = mem_q & ~pix_mask;
    end
  end

  assign mem_re = cmd.capture | cmd.fl_rd;
  assign mem_ra = cmd.fl_rd ? fl_addr : pix_addr;
  assign mem_we = cmd.clr_step
                  | (cmd.pix_done & inside_r
                     & (type_r inside {pfb_pkg::REQ_WRITE, pfb_pkg::REQ_INVERT}));
  assign mem_wa = cmd.clr_step ? sweep_r : addr_r;
  assign mem_wd = cmd.clr_step ? 8'd0 : mod_byte;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  // sweep and column counters
  always_comb begin
    sweep_nxt = sweep_r;
    col_nxt   = col_r;
    if (cmd.clr_step) sweep_nxt = sts.clr_end ? '0 : sweep_r + AW'(1);
    if (cmd.fl_rd) col_nxt = sts.col_end ? '0 : col_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r  <= '0;
      col_r    <= '0;
      pack_d_r <= 1'b0;
    end else begin
      sweep_r  <= sweep_nxt;
      col_r    <= col_nxt;
      pack_d_r <= cmd.fl_rd;
    end
  end

  // byte packing, one byte per cycle behind the read
  assign slot      = col_d_r[2:0];
  assign word_ins  = ((slot == 3'd0) ? 64'd0 : word_r) | (64'(mem_q) << {slot, 3'b000});
  assign page_end  = col_d_r == CW'(WIDTH - 1);
  assign group_end = (slot == 3'd7) || page_end;

  always_ff @(posedge clk) begin
    col_d_r <= col_r;
    if (pack_d_r) word_r <= word_ins;
  end

  // result register
  always_comb begin
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    if (cmd.emit_cmd) begin
      out_valid_nxt          = 1'b1;
      out_res_nxt.out_word   = {32'd0, 8'h00, pfb_pkg::CMD_COLH, pfb_pkg::CMD_START,
                                pfb_pkg::CMD_PAGE | (8'(in_req.page_index) & pfb_pkg::NIBBLE)};
      out_res_nxt.byte_count = 4'd4;
      out_res_nxt.is_command = 1'b1;
      out_res_nxt.read_pixel = 1'b0;
      out_res_nxt.last       = 1'b0;
    end else if (pack_d_r && group_end) begin
      out_valid_nxt          = 1'b1;
      out_res_nxt.out_word   = word_ins;
      out_res_nxt.byte_count = {1'b0, slot} + 4'd1;
      out_res_nxt.is_command = 1'b0;
      out_res_nxt.read_pixel = 1'b0;
      out_res_nxt.last       = page_end;
    end else if (cmd.pix_done && type_r == pfb_pkg::REQ_READ) begin
      out_valid_nxt          = 1'b1;
      out_res_nxt.out_word   = 64'd0;
      out_res_nxt.byte_count = 4'd0;
      out_res_nxt.is_command = 1'b0;
      out_res_nxt.read_pixel = inside_r & mem_q[bit_r];
      out_res_nxt.last       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_res    = out_res_r;

endmodule

### src/page_framebuffer_pixel_engine.sv
// top level of the page-organized monochrome frame store engine
// instantiates pfb_ctrl and pfb_datapath; uses pfb_pkg
//
// Requests enter on in_req and are taken at a clock edge with start high and
// busy low. Results leave on out_res, each valid for the one cycle out_strobe
// is high; the receiver must take them as they come.
// Pixel write, read and invert: busy in the ST_PIX state after the request, so
// the next request waits; a read result is registered from the captured byte.
// Clear store: busy zeroing PAGES*WIDTH bytes (1024 by default), one per cycle.
// Flush page: the command word strobes in the cycle after acceptance, then data
// words of up to eight bytes each, the final one marked last; busy through the
// ST_FRD reads of all columns and ST_FDRAIN, one store byte read per cycle.
// Out-of-range flush pages and unknown request codes are dropped without busy.
// After reset the store is zeroed by a clearing pass over all PAGES*WIDTH bytes
// with busy high; no request is taken before it ends.
module page_framebuffer_pixel_engine #(
  parameter int WIDTH  = pfb_pkg::DEF_WIDTH,
  parameter int HEIGHT = pfb_pkg::DEF_HEIGHT,
  parameter int PAGES  = pfb_pkg::DEF_PAGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pfb_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output pfb_pkg::out_res_t out_res
);

  pfb_pkg::pfb_cmd_t cmd;
  pfb_pkg::pfb_sts_t sts;

  pfb_ctrl #(
    .PAGES(PAGES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req_type   (in_req.req_type),
    .page_index (in_req.page_index),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  pfb_datapath #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT),
    .PAGES  (PAGES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule
